>>> src/csv_field_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// csv_field_tokenizer_macros.svh
// Assertion macros shared by the tokenizer checkers.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_TOKENIZER_MACROS_SVH
`define CSV_FIELD_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSVT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSVT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/csvt_pkg.sv
// ----------------------------------------------------------------------------
// csvt_pkg
// Types, codes and reset values shared by the CSV field tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package csvt_pkg;

	localparam int MASK_COLUMNS_DEF = 64;
	localparam int COLUMN_WIDTH_DEF = 16;
	localparam int CFG_DATA_W       = 64;
	localparam int CFG_INDEX_W      = 3;
	localparam int OUTQ_DEPTH       = 4;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_SEP     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_QUOTE_CHAR    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RECORD_SEP    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_NEWLINE  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SELECT_ENABLE = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_SELECT_MASK   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_BEYOND   = 3'd6;

	// Register reset values
	localparam logic [7:0] FIELD_SEP_RST  = 8'd44;
	localparam logic [7:0] QUOTE_CHAR_RST = 8'd34;
	localparam logic [7:0] RECORD_SEP_RST = 8'd10;

	localparam logic [7:0] BYTE_LF  = 8'd10;
	localparam logic [7:0] BYTE_CR  = 8'd13;
	localparam logic [7:0] BYTE_NUL = 8'd0;

	// Input kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_EOI  = 1'b1;

	// Result kinds
	localparam logic OUT_CONTENT   = 1'b0;
	localparam logic OUT_FIELD_END = 1'b1;

	// Field terminators
	localparam logic [1:0] TERM_SEP = 2'd0;
	localparam logic [1:0] TERM_REC = 2'd1;
	localparam logic [1:0] TERM_EOI = 2'd2;

	typedef enum logic [2:0] {
		QM_UNQ     = 3'b001,
		QM_QUOTED  = 3'b010,
		QM_PENDING = 3'b100
	} qm_t;

	typedef struct packed {
		logic [7:0] field_sep;
		logic [7:0] quote_char;
		logic [7:0] record_sep;
		logic       auto_newline;
		logic       select_enable;
		logic       keep_beyond;
	} cfg_t;

	// One result without its column tag
	typedef struct packed {
		logic       okind;
		logic [7:0] obyte;
		logic [1:0] term;
	} item_t;

	localparam item_t CR_ITEM = '{okind: OUT_CONTENT, obyte: BYTE_CR, term: TERM_SEP};

endpackage

`default_nettype wire

>>> src/csvt_outq.sv
// ----------------------------------------------------------------------------
// csvt_outq
// Result queue: takes up to two entries per cycle, gives one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_outq
	import csvt_pkg::*;
#(
	parameter int W     = 8,
	parameter int DEPTH = OUTQ_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [1:0]   push_n,
	input  wire logic [W-1:0] d0,
	input  wire logic [W-1:0] d1,
	output logic              room,
	output logic              valid,
	input  wire logic         pop,
	output logic [W-1:0]      head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= d0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_q + PW'(1)] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push_n);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

	assign room  = (cnt_q <= CW'(DEPTH - 2));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_q];

endmodule

`default_nettype wire

>>> src/csvt_step.sv
// ----------------------------------------------------------------------------
// csvt_step
// Quote tracking, CR hold, column count and selection for one input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_step
	import csvt_pkg::*;
#(
	parameter int MASK_COLUMNS = MASK_COLUMNS_DEF,
	parameter int COLUMN_WIDTH = COLUMN_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    advance,
	input  wire logic                    kind,
	input  wire logic [7:0]              c,
	input  wire cfg_t                    cfg,
	input  wire logic [MASK_COLUMNS-1:0] mask,
	output logic [1:0]                   res_n,
	output item_t                        r0,
	output item_t                        r1,
	output logic [COLUMN_WIDTH-1:0]      column,
	output logic                         selected
);

	localparam int IDXW = $clog2(MASK_COLUMNS);

	qm_t                     qm_q, qm_d;
	logic                    held_q, held_d;
	logic [COLUMN_WIDTH-1:0] col_q, col_d;

	logic                    rec;
	logic                    nul_drop;
	logic                    cont;
	logic                    cr_emit;
	logic                    main_v;
	item_t                   main;
	logic                    in_mask;
	logic [MASK_COLUMNS-1:0] shifted;

	always_comb begin
		rec      = cfg.auto_newline ? (c == BYTE_LF) : (c == cfg.record_sep);
		nul_drop = (c == BYTE_NUL) && (cfg.field_sep != BYTE_NUL)
			&& (cfg.auto_newline || (cfg.record_sep != BYTE_NUL));
		cont     = 1'b0;
		cr_emit  = 1'b0;
		main_v   = 1'b0;
		main     = '{okind: OUT_CONTENT, obyte: c, term: TERM_SEP};
		qm_d     = qm_q;
		held_d   = held_q;
		col_d    = col_q;
		priority if (kind == KIND_EOI) begin
			cr_emit = held_q;
			held_d  = 1'b0;
			main_v  = 1'b1;
			main    = '{okind: OUT_FIELD_END, obyte: BYTE_NUL, term: TERM_EOI};
			qm_d    = QM_UNQ;
			col_d   = '0;
		end else if (nul_drop) begin
			qm_d = qm_q;
		end else if (qm_q == QM_QUOTED) begin
			if (c == cfg.quote_char) begin
				qm_d = QM_PENDING;
			end else begin
				cont = 1'b1;
			end
		end else if ((qm_q == QM_PENDING) && (c == cfg.quote_char)) begin
			// doubled quote: one literal quote
			qm_d = QM_QUOTED;
			cont = 1'b1;
		end else begin
			qm_d = QM_UNQ;
			if (rec || (c == cfg.field_sep)) begin
				// LF after CR in auto-newline mode drops the CR
				cr_emit = held_q && !(rec && cfg.auto_newline);
				held_d  = 1'b0;
				main_v  = 1'b1;
				main    = '{okind: OUT_FIELD_END, obyte: BYTE_NUL,
					term: rec ? TERM_REC : TERM_SEP};
				if (rec) begin
					col_d = '0;
				end else if (col_q != '1) begin
					col_d = col_q + COLUMN_WIDTH'(1);
				end
			end else if (c == cfg.quote_char) begin
				qm_d = QM_QUOTED;
			end else begin
				cont = 1'b1;
			end
		end
		if (cont) begin
			cr_emit = held_q;
			if (cfg.auto_newline && (c == BYTE_CR)) begin
				held_d = 1'b1;
			end else begin
				held_d = 1'b0;
				main_v = 1'b1;
			end
		end
	end

	assign res_n = {1'b0, cr_emit} + {1'b0, main_v};
	assign r0    = cr_emit ? CR_ITEM : main;
	assign r1    = main;

	// Column selection; a column is beyond the mask when no mask bit sits at or above it
	always_comb begin
		in_mask  = (col_q < COLUMN_WIDTH'(MASK_COLUMNS));
		shifted  = mask >> col_q[IDXW-1:0];
		if (!cfg.select_enable) begin
			selected = 1'b1;
		end else if (in_mask) begin
			selected = shifted[0] || (cfg.keep_beyond && (shifted == '0));
		end else begin
			selected = cfg.keep_beyond;
		end
	end

	assign column = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qm_q   <= QM_UNQ;
			held_q <= 1'b0;
			col_q  <= '0;
		end else if (advance) begin
			qm_q   <= qm_d;
			held_q <= held_d;
			col_q  <= col_d;
		end
	end

endmodule

`default_nettype wire

>>> src/csv_field_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Streaming CSV field splitter with quoting, CRLF handling and column select.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, kind, in_byte) carries one byte or an
//   end-of-input mark per transaction. Output channel (out_valid / out_stall)
//   carries content bytes and field-end marks tagged with column, selected,
//   terminator and last. Each input transaction yields zero, one or two
//   output transactions; last marks the final one.
//   Path: the results of an accepted byte pass the input register, then the
//   result queue, before they show on the output.
//   Throughput: one input transaction per cycle while every byte gives at
//   most one result and out_stall stays low; a byte that also flushes a held
//   CR gives two results and the single-entry-per-cycle output port sets the
//   pace.
//   Stall: a four-entry result queue sits between the step logic and the
//   output port; the input stalls while it has fewer than two free entries.
//   Reset (arst_n low): registers return to their defaults, quoting ends, no
//   CR is held, column goes to zero and the queue empties.
//   Configuration writes (cfg_we, cfg_index, cfg_data) are meant for idle
//   periods; indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer
	import csvt_pkg::*;
#(
	parameter int MASK_COLUMNS = MASK_COLUMNS_DEF,
	parameter int COLUMN_WIDTH = COLUMN_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   kind,
	input  wire logic [7:0]             in_byte,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        out_kind,
	output logic [7:0]                  out_byte,
	output logic [COLUMN_WIDTH-1:0]     column,
	output logic                        selected,
	output logic [1:0]                  terminator,
	output logic                        last
);

	// queue entry: item, selected, last, column
	localparam int QW = $bits(item_t) + 2 + COLUMN_WIDTH;

	cfg_t                    cfg_q;
	logic [MASK_COLUMNS-1:0] mask_q;

	logic                    valid_s1;
	logic                    kind_s1;
	logic [7:0]              byte_s1;

	logic                    advance;
	logic                    room;
	logic [1:0]              res_n;
	logic [1:0]              push_n;
	item_t                   r0;
	item_t                   r1;
	logic [COLUMN_WIDTH-1:0] step_col;
	logic                    step_sel;
	logic [QW-1:0]           d0;
	logic [QW-1:0]           d1;
	logic [QW-1:0]           head;
	item_t                   head_item;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.field_sep     <= FIELD_SEP_RST;
			cfg_q.quote_char    <= QUOTE_CHAR_RST;
			cfg_q.record_sep    <= RECORD_SEP_RST;
			cfg_q.auto_newline  <= 1'b1;
			cfg_q.select_enable <= 1'b0;
			cfg_q.keep_beyond   <= 1'b0;
			mask_q              <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIELD_SEP:     cfg_q.field_sep     <= cfg_data[7:0];
				CFG_QUOTE_CHAR:    cfg_q.quote_char    <= cfg_data[7:0];
				CFG_RECORD_SEP:    cfg_q.record_sep    <= cfg_data[7:0];
				CFG_AUTO_NEWLINE:  cfg_q.auto_newline  <= cfg_data[0];
				CFG_SELECT_ENABLE: cfg_q.select_enable <= cfg_data[0];
				CFG_SELECT_MASK:   mask_q              <= cfg_data[MASK_COLUMNS-1:0];
				CFG_KEEP_BEYOND:   cfg_q.keep_beyond   <= cfg_data[0];
				default: begin
					// unused index: drop the write
				end
			endcase
		end
	end

	// Advance the held item whenever the queue can take two more entries
	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input payload register; holds while stalled
	always_ff @(posedge clk) begin
		if (!in_stall) begin
			kind_s1 <= kind;
			byte_s1 <= in_byte;
		end
	end

	csvt_step #(
		.MASK_COLUMNS(MASK_COLUMNS),
		.COLUMN_WIDTH(COLUMN_WIDTH)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.kind     (kind_s1),
		.c        (byte_s1),
		.cfg      (cfg_q),
		.mask     (mask_q),
		.res_n    (res_n),
		.r0       (r0),
		.r1       (r1),
		.column   (step_col),
		.selected (step_sel)
	);

	// Both results of one byte share its column; last goes on the final one
	assign push_n = advance ? res_n : 2'd0;
	assign d0     = {r0, step_sel, (res_n == 2'd1), step_col};
	assign d1     = {r1, step_sel, 1'b1, step_col};

	csvt_outq #(
		.W     (QW),
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.d0     (d0),
		.d1     (d1),
		.room   (room),
		.valid  (out_valid),
		.pop    (out_valid && !out_stall),
		.head   (head)
	);

	assign {head_item, selected, last, column} = head;
	assign out_kind   = head_item.okind;
	assign out_byte   = head_item.obyte;
	assign terminator = head_item.term;

endmodule

`default_nettype wire

>>> src/csvt_checker.sv
// ----------------------------------------------------------------------------
// csvt_checker
// Port-level checks on the tokenizer output channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "csv_field_tokenizer_macros.svh"

module csvt_checker
	import csvt_pkg::*;
#(
	parameter int COLUMN_WIDTH = COLUMN_WIDTH_DEF
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    out_valid,
	input wire logic                    out_stall,
	input wire logic                    out_kind,
	input wire logic [7:0]              out_byte,
	input wire logic [COLUMN_WIDTH-1:0] column,
	input wire logic                    selected,
	input wire logic [1:0]              terminator,
	input wire logic                    last
);

	logic [COLUMN_WIDTH+12:0] out_payload;

	assign out_payload = {out_kind, out_byte, column, selected, terminator, last};

	`CSVT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_payload), "stalled output transaction changed")

	`CSVT_ASSERT_NOW(a_end_last, clk, arst_n, out_valid && (out_kind == OUT_FIELD_END),
		last && (out_byte == BYTE_NUL), "field end not last or carries a byte")

	`CSVT_ASSERT_NOW(a_content_term, clk, arst_n, out_valid && (out_kind == OUT_CONTENT),
		terminator == TERM_SEP, "content byte carries a terminator")

	`CSVT_ASSERT_NOW(a_term_code, clk, arst_n, out_valid,
		(terminator == TERM_SEP) || (terminator == TERM_REC) || (terminator == TERM_EOI),
		"terminator code out of range")

endmodule

bind csv_field_tokenizer csvt_checker #(.COLUMN_WIDTH(COLUMN_WIDTH)) u_csvt_checker (.*);

`default_nettype wire

>>> test/csvt_tb_pkg.sv
// ----------------------------------------------------------------------------
// csvt_tb_pkg
// Token predictor and scoreboard for the CSV field tokenizer testbench.
// Holds its own copy of the registers and the quoting, CR and column state.
// It also keeps the queue of tokens that the block still owes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package csvt_tb_pkg;
	import csvt_pkg::*;

	localparam int COL_W = COLUMN_WIDTH_DEF;

	typedef struct packed {
		logic             okind;
		logic [7:0]       obyte;
		logic [COL_W-1:0] col;
		logic             sel;
		logic [1:0]       term;
		logic             lst;
	} token_t;

	class token_scoreboard;
		cfg_t             cfg;
		logic [63:0]      select_mask;
		qm_t              quote_state;
		bit               cr_held;
		logic [COL_W-1:0] col_count;
		token_t           upcoming_tokens[$];
		token_t           fresh[$];
		int               mismatches;

		function new();
			cfg = '{field_sep: FIELD_SEP_RST, quote_char: QUOTE_CHAR_RST,
				record_sep: RECORD_SEP_RST, auto_newline: 1'b1,
				select_enable: 1'b0, keep_beyond: 1'b0};
			select_mask = '0;
			quote_state = QM_UNQ;
			cr_held = 1'b0;
			col_count = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_FIELD_SEP:     cfg.field_sep = value[7:0];
				CFG_QUOTE_CHAR:    cfg.quote_char = value[7:0];
				CFG_RECORD_SEP:    cfg.record_sep = value[7:0];
				CFG_AUTO_NEWLINE:  cfg.auto_newline = value[0];
				CFG_SELECT_ENABLE: cfg.select_enable = value[0];
				CFG_SELECT_MASK:   select_mask = value;
				CFG_KEEP_BEYOND:   cfg.keep_beyond = value[0];
				default: ;
			endcase
		endfunction

		function logic is_selected(logic [COL_W-1:0] col);
			int top;
			top = -1;
			if (!cfg.select_enable)
				return 1'b1;
			for (int i = 0; i < MASK_COLUMNS_DEF; i++)
				if (select_mask[i])
					top = i;
			// open-ended range past the highest mask bit
			if (cfg.keep_beyond && int'(col) > top)
				return 1'b1;
			if (col >= MASK_COLUMNS_DEF)
				return 1'b0;
			return select_mask[col];
		endfunction

		function void push(logic okind, logic [7:0] obyte, logic [1:0] term);
			token_t t;
			t.okind = okind;
			t.obyte = obyte;
			t.col = col_count;
			t.sel = is_selected(col_count);
			t.term = term;
			t.lst = 1'b0;
			fresh.push_back(t);
		endfunction

		function void flush_cr();
			if (cr_held) begin
				push(OUT_CONTENT, BYTE_CR, TERM_SEP);
				cr_held = 1'b0;
			end
		endfunction

		function void take_content(logic [7:0] c);
			flush_cr();
			// hold a CR back until we know whether LF follows
			if (cfg.auto_newline && c == BYTE_CR)
				cr_held = 1'b1;
			else
				push(OUT_CONTENT, c, TERM_SEP);
		endfunction

		// Predict the tokens of one accepted input transaction.
		function void note_transaction(logic k, logic [7:0] c);
			logic   rec;
			token_t t;
			fresh.delete();
			if (k == KIND_EOI) begin
				flush_cr();
				push(OUT_FIELD_END, 8'h00, TERM_EOI);
				quote_state = QM_UNQ;
				col_count = '0;
			end else if (c == BYTE_NUL && cfg.field_sep != BYTE_NUL &&
					(cfg.auto_newline || cfg.record_sep != BYTE_NUL)) begin
				// drop the NUL without a trace
			end else if (quote_state == QM_QUOTED) begin
				if (c == cfg.quote_char)
					quote_state = QM_PENDING;
				else
					take_content(c);
			end else if (quote_state == QM_PENDING && c == cfg.quote_char) begin
				quote_state = QM_QUOTED;
				take_content(c);
			end else begin
				quote_state = QM_UNQ;
				rec = cfg.auto_newline ? (c == BYTE_LF) : (c == cfg.record_sep);
				if (rec || c == cfg.field_sep) begin
					if (rec && cfg.auto_newline)
						cr_held = 1'b0;
					else
						flush_cr();
					push(OUT_FIELD_END, 8'h00, rec ? TERM_REC : TERM_SEP);
					if (rec)
						col_count = '0;
					else if (col_count != '1)
						col_count++;
				end else if (c == cfg.quote_char) begin
					quote_state = QM_QUOTED;
				end else begin
					take_content(c);
				end
			end
			for (int i = 0; i < fresh.size(); i++) begin
				t = fresh[i];
				t.lst = (i == fresh.size() - 1);
				upcoming_tokens.push_back(t);
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				mismatches++;
				$error("%s: expected %0h, got %0h", name, want, got);
			end
		endfunction

		function void check_token(token_t got);
			token_t want;
			if (upcoming_tokens.size() == 0) begin
				mismatches++;
				$error("token with none expected: kind %0d byte %02h column %0d",
					got.okind, got.obyte, got.col);
				return;
			end
			want = upcoming_tokens.pop_front();
			compare_field("out_kind", want.okind, got.okind);
			compare_field("out_byte", want.obyte, got.obyte);
			compare_field("column", want.col, got.col);
			compare_field("selected", want.sel, got.sel);
			compare_field("terminator", want.term, got.term);
			compare_field("last", want.lst, got.lst);
		endfunction
	endclass

endpackage

>>> test/csv_field_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer_tb
// Self-checking testbench for the streaming CSV field tokenizer.
// A directed opener hits quoting, CR/LF, NUL and end-of-input corners, then
// random records with noise run under several register settings. Every
// accepted transaction is predicted by the scoreboard and every output token
// is compared field by field. A long record runs the column counter past
// the selection mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module csv_field_tokenizer_tb;
	import csvt_pkg::*;
	import csvt_tb_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 100;
	localparam int NUM_SETTINGS  = 5;

	// Index past the end of the register list; the block must ignore it
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

	// Receiver behaviors
	localparam int RX_FREE     = 0;
	localparam int RX_RANDOM   = 1;
	localparam int RX_PERIODIC = 2;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic                   kind;
	logic [7:0]             in_byte;
	logic                   out_valid;
	logic                   out_stall;
	logic                   out_kind;
	logic [7:0]             out_byte;
	logic [COL_W-1:0]       column;
	logic                   selected;
	logic [1:0]             terminator;
	logic                   last;

	token_scoreboard sb;
	int unsigned     cycle_count = 0;
	int              items_sent = 0;
	int              burst_left = 0;
	bit              gaps_on = 1'b0;
	int              rx_mode = RX_FREE;
	int              rx_hold = 0;
	int unsigned     rx_phase = 0;

	csv_field_tokenizer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_kind(out_kind),
		.out_byte(out_byte),
		.column(column),
		.selected(selected),
		.terminator(terminator),
		.last(last)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Bound the run: a missing token or a hung handshake ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: a forced hold-off wins, else follow the current stall pattern.
	// Count the hold-off down here so the sender can keep offering meanwhile.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_stall = 1'b1;
			rx_hold--;
		end else begin
			case (rx_mode)
				RX_RANDOM: out_stall = ($urandom_range(0, 99) < 40);
				RX_PERIODIC: out_stall = ((rx_phase % 7) < 3);
				default: out_stall = 1'b0;
			endcase
		end
		rx_phase++;
	end

	// Sample both channels at the rising edge, before the block updates.
	// Check outputs first; a new input cannot reach the output this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_token(token_t'{out_kind, out_byte, column, selected,
					terminator, last});
			if (in_valid && !in_stall)
				sb.note_transaction(kind, in_byte);
		end
	end

	// Write one register; keep the scoreboard copy in step with the block.
	task automatic program_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Offer one transaction and hold it until the block takes it.
	// Leave valid high so back-to-back items need no extra edge.
	task automatic send_item(logic k, logic [7:0] b);
		@(negedge clk);
		in_valid = 1'b1;
		kind = k;
		in_byte = b;
		do begin
			@(posedge clk);
		end while (in_stall);
		items_sent++;
	endtask

	task automatic pause_sender(int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Send in bursts of random length with random gaps between them.
	task automatic offer(logic k, logic [7:0] b);
		if (gaps_on) begin
			if (burst_left == 0) begin
				pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) :
					$urandom_range(1, 4));
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		send_item(k, b);
	endtask

	// Stop sending and wait until the block owes nothing, then let it settle.
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.upcoming_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly lower-case letters, sometimes any byte at all.
	function automatic logic [7:0] plain_byte();
		if ($urandom_range(0, 3) != 0)
			return 8'($urandom_range(8'h61, 8'h7a));
		return 8'($urandom_range(0, 255));
	endfunction

	// Bias toward the bytes that steer the state machine.
	function automatic logic [7:0] odd_byte();
		case ($urandom_range(0, 5))
			0: return BYTE_NUL;
			1: return BYTE_CR;
			2: return BYTE_LF;
			3: return sb.cfg.field_sep;
			4: return sb.cfg.quote_char;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_field();
		int len;
		len = $urandom_range(0, 6);
		if ($urandom_range(0, 2) == 0) begin
			// quoted field: embed separators, CR, LF and doubled quotes
			offer(KIND_DATA, sb.cfg.quote_char);
			repeat (len) begin
				case ($urandom_range(0, 9))
					0: begin
						offer(KIND_DATA, sb.cfg.quote_char);
						offer(KIND_DATA, sb.cfg.quote_char);
					end
					1: offer(KIND_DATA, sb.cfg.field_sep);
					2: offer(KIND_DATA, BYTE_CR);
					3: offer(KIND_DATA, BYTE_LF);
					default: offer(KIND_DATA, plain_byte());
				endcase
			end
			offer(KIND_DATA, sb.cfg.quote_char);
		end else begin
			repeat (len) begin
				if ($urandom_range(0, 9) == 0)
					offer(KIND_DATA, BYTE_CR);
				else
					offer(KIND_DATA, plain_byte());
			end
		end
	endtask

	task automatic send_record();
		int nfields;
		nfields = $urandom_range(1, 6);
		for (int f = 0; f < nfields; f++) begin
			if (f > 0)
				offer(KIND_DATA, sb.cfg.field_sep);
			send_field();
		end
		// end the record; now and then end the whole input instead
		if ($urandom_range(0, 7) == 0) begin
			offer(KIND_EOI, 8'($urandom_range(0, 255)));
		end else if (sb.cfg.auto_newline) begin
			if ($urandom_range(0, 1) == 1)
				offer(KIND_DATA, BYTE_CR);
			offer(KIND_DATA, BYTE_LF);
		end else begin
			offer(KIND_DATA, sb.cfg.record_sep);
		end
	endtask

	// Broken sequences: loose control bytes, stray end-of-input marks.
	task automatic send_noise();
		repeat ($urandom_range(1, 5)) begin
			if ($urandom_range(0, 9) == 0)
				offer(KIND_EOI, 8'($urandom_range(0, 255)));
			else
				offer(KIND_DATA, odd_byte());
		end
	endtask

	task automatic random_traffic(int n);
		int stop_at;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 6) == 0)
				send_noise();
			else
				send_record();
		end
	endtask

	task automatic apply_setting(int p);
		case (p)
			0: begin
				// alternate separators, record end byte in use, random mask
				program_reg(CFG_FIELD_SEP, 64'h3b);
				program_reg(CFG_QUOTE_CHAR, 64'h27);
				program_reg(CFG_RECORD_SEP, 64'hff);
				program_reg(CFG_AUTO_NEWLINE, 64'h0);
				program_reg(CFG_SELECT_ENABLE, 64'h1);
				program_reg(CFG_SELECT_MASK, {$urandom(), $urandom()});
				program_reg(CFG_KEEP_BEYOND, 64'h1);
				program_reg(CFG_UNUSED, {$urandom(), $urandom()});
			end
			1: begin
				// NUL separates fields and ends records, so it is a real byte
				program_reg(CFG_FIELD_SEP, 64'h00);
				program_reg(CFG_QUOTE_CHAR, 64'hff);
				program_reg(CFG_RECORD_SEP, 64'h00);
				program_reg(CFG_SELECT_MASK, '1);
				program_reg(CFG_KEEP_BEYOND, 64'h0);
			end
			2: begin
				// field and record separators clash; record end wins
				program_reg(CFG_FIELD_SEP, 64'hff);
				program_reg(CFG_QUOTE_CHAR, 64'h00);
				program_reg(CFG_RECORD_SEP, 64'hff);
				program_reg(CFG_SELECT_MASK, 64'h0);
				program_reg(CFG_KEEP_BEYOND, 64'h1);
			end
			3: begin
				// LF as field separator clashes with auto newline
				program_reg(CFG_FIELD_SEP, {56'h0, BYTE_LF});
				program_reg(CFG_QUOTE_CHAR, {56'h0, QUOTE_CHAR_RST});
				program_reg(CFG_RECORD_SEP, 64'h2c);
				program_reg(CFG_AUTO_NEWLINE, 64'h1);
				program_reg(CFG_SELECT_MASK, 64'h8000_0000_0000_0005);
				program_reg(CFG_KEEP_BEYOND, 64'h0);
			end
			default: begin
				// back to plain CSV, selection off
				program_reg(CFG_FIELD_SEP, {56'h0, FIELD_SEP_RST});
				program_reg(CFG_RECORD_SEP, {56'h0, RECORD_SEP_RST});
				program_reg(CFG_SELECT_ENABLE, 64'h0);
				program_reg(CFG_SELECT_MASK, {$urandom(), $urandom()});
			end
		endcase
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_DATA;
		in_byte = '0;
		out_stall = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opener under reset registers, no idling on either side.
		// Plain fields with an all-ones content byte.
		send_item(KIND_DATA, "a");
		send_item(KIND_DATA, FIELD_SEP_RST);
		send_item(KIND_DATA, 8'hff);
		send_item(KIND_DATA, BYTE_LF);
		// quoted field with a doubled quote, then a closing quote
		send_item(KIND_DATA, QUOTE_CHAR_RST);
		send_item(KIND_DATA, "x");
		send_item(KIND_DATA, QUOTE_CHAR_RST);
		send_item(KIND_DATA, QUOTE_CHAR_RST);
		send_item(KIND_DATA, QUOTE_CHAR_RST);
		send_item(KIND_DATA, FIELD_SEP_RST);
		// CR right before LF is dropped
		send_item(KIND_DATA, "c");
		send_item(KIND_DATA, BYTE_CR);
		send_item(KIND_DATA, BYTE_LF);
		// held CR flushed by a content byte and by a field separator
		send_item(KIND_DATA, BYTE_CR);
		send_item(KIND_DATA, "d");
		send_item(KIND_DATA, BYTE_CR);
		send_item(KIND_DATA, FIELD_SEP_RST);
		send_item(KIND_DATA, BYTE_NUL);
		// pending quote closed by end of input
		send_item(KIND_DATA, QUOTE_CHAR_RST);
		send_item(KIND_DATA, "z");
		send_item(KIND_DATA, QUOTE_CHAR_RST);
		send_item(KIND_EOI, 8'h00);
		// held CR flushed by end of input, then an empty final field
		send_item(KIND_DATA, BYTE_CR);
		send_item(KIND_EOI, 8'hff);
		send_item(KIND_EOI, 8'h00);
		drain_results();

		// Random records under each register setting.
		for (int p = 0; p < NUM_SETTINGS; p++) begin
			apply_setting(p);
			rx_mode = (p + 1) % 3;
			gaps_on = (p != 2);
			random_traffic(PHASE_ITEMS);
			drain_results();
		end

		// Hold the receiver off while the sender streams; the result queue
		// fills and the input must stall.
		rx_mode = RX_RANDOM;
		gaps_on = 1'b0;
		rx_hold = 400;
		random_traffic(80);
		drain_results();

		// Column counter: run past the mask without keep-beyond.
		rx_mode = RX_FREE;
		program_reg(CFG_SELECT_ENABLE, 64'h1);
		program_reg(CFG_SELECT_MASK, 64'h1 << $urandom_range(0, 63));
		program_reg(CFG_KEEP_BEYOND, 64'h0);
		send_item(KIND_EOI, 8'h00);
		repeat (70) send_item(KIND_DATA, sb.cfg.field_sep);
		send_item(KIND_DATA, "q");
		drain_results();

		if (sb.mismatches == 0 && sb.upcoming_tokens.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
